[rtl/sle_pkg.sv]
// sle_pkg: shared codes and types for the sequential list engine
// depends on nothing; imported by sle_cell and sequential_list_engine
`default_nettype none

package sle_pkg;

  // command codes
  localparam logic [2:0] CMD_APPEND     = 3'd0;
  localparam logic [2:0] CMD_INSERT     = 3'd1;
  localparam logic [2:0] CMD_DELETE     = 3'd2;
  localparam logic [2:0] CMD_FIND_NAME  = 3'd3;
  localparam logic [2:0] CMD_FIND_PLACE = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_BAD_POS   = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // stream payload widths (fixed by the field layout)
  localparam int unsigned NAME_W  = 64;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned PORT_CW = 16;
  localparam int unsigned TDATA_W = 112;

  // what every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage : sle_pkg

`default_nettype wire

[rtl/sle_cell.sv]
// sle_cell: one list slot of the chain, holds name key and coordinates
// depends on sle_pkg for the cell operation codes
`default_nettype none

module sle_cell #(
  parameter int unsigned IW    = 6,
  parameter int unsigned EW    = 96,
  parameter int unsigned INDEX = 0
) (
  input  wire logic              clk,
  input  wire sle_pkg::cell_op_t op,
  input  wire logic [IW-1:0]     slot,
  input  wire logic [EW-1:0]     new_entry,
  input  wire logic [EW-1:0]     from_prev,
  input  wire logic [EW-1:0]     from_next,
  output logic      [EW-1:0]     entry
);
  import sle_pkg::*;

  localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

  // slot contents: hold, rotate toward cell 0, open a gap, or close one
  always_ff @(posedge clk) begin
    case (op)
      CELL_ROTATE: begin
        entry <= from_next;
      end
      CELL_SHIFT_UP: begin
        if (MY_INDEX == slot) begin
          entry <= new_entry;
        end else if (MY_INDEX > slot) begin
          entry <= from_prev;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (MY_INDEX >= slot) begin
          entry <= from_next;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule : sle_cell

`default_nettype wire

[rtl/sequential_list_engine.sv]
// sequential_list_engine: ordered list of name/place entries in a ring of cells
// depends on sle_pkg and sle_cell
`default_nettype none

// channel  dir  fields (lsb first)
// s_axis   in   cmd[2:0] position[9:3] name_key[73:10] coord_x[89:74] coord_y[105:90]
// m_axis   out  status[1:0] found_position[8:2] found_name[72:9] found_x[88:73]
//               found_y[104:89]
//
// append and insert pass through the shift state (ST_SHIFT) to the result
// finds rotate the whole cell ring past the head cell before the result, and a good
// delete follows that rotation with the closing shift of the chain
// rejected commands and unknown codes go straight to the result state (ST_DONE)
// one command is worked at a time; a new one is taken while a result still waits
// rst clears the entry count and the handshake state; cell contents are not cleared

module sequential_list_engine #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // cmd, position, name_key, coord_x, coord_y
  input  wire logic [sle_pkg::TDATA_W-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // status, found_position, found_name, found_x, found_y
  output logic      [sle_pkg::TDATA_W-1:0]   m_tdata
);
  import sle_pkg::*;

  localparam int unsigned IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned PW  = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int unsigned EW  = NAME_W + 2 * COORD_WIDTH;
  localparam int unsigned OUT_BITS = 2 + POS_W + NAME_W + 2 * PORT_CW;

  // sign-extend a port coordinate, then keep COORD_WIDTH bits
  function automatic logic [COORD_WIDTH-1:0] coord_in(input logic [PORT_CW-1:0] v);
    logic [31:0] w;
    w = {{(32 - PORT_CW){v[PORT_CW-1]}}, v};
    return w[COORD_WIDTH-1:0];
  endfunction

  // stored coordinate as it leaves on the port (zero-extended, low bits)
  function automatic logic [PORT_CW-1:0] coord_out(input logic [COORD_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[PORT_CW-1:0];
  endfunction

  // input field split
  logic [2:0]             in_cmd;
  logic [POS_W-1:0]       in_pos;
  logic [NAME_W-1:0]      in_key;
  logic [COORD_WIDTH-1:0] in_x;
  logic [COORD_WIDTH-1:0] in_y;

  assign in_cmd = s_tdata[2:0];
  assign in_pos = s_tdata[9:3];
  assign in_key = s_tdata[73:10];
  assign in_x   = coord_in(s_tdata[89:74]);
  assign in_y   = coord_in(s_tdata[105:90]);

  // registers
  state_t                 state, state_next;
  logic [CW-1:0]          count;
  logic [IW-1:0]          step;
  logic [IW-1:0]          slot;
  logic [2:0]             cmd;
  logic [NAME_W-1:0]      key;
  logic [COORD_WIDTH-1:0] cx;
  logic [COORD_WIDTH-1:0] cy;
  logic                   found;
  logic [1:0]             res_status;
  logic [POS_W-1:0]       res_pos;
  logic [EW-1:0]          res_entry;
  cell_op_t               cell_op;

  // position checks at transfer time
  logic [PW-1:0] pos_e;
  logic [PW-1:0] cnt_e;
  logic          ins_ok;
  logic          del_ok;
  logic          is_full;
  logic          accept;

  assign pos_e   = PW'(in_pos);
  assign cnt_e   = PW'(count);
  assign ins_ok  = (pos_e != '0) && (pos_e <= cnt_e + PW'(1));
  assign del_ok  = (pos_e != '0) && (pos_e <= cnt_e);
  assign is_full = (count == CW'(DEPTH));
  assign accept  = s_tvalid && s_tready;

  // ring of cells: cell i hands to i-1 on rotate, head is cell 0
  logic [EW-1:0] cell_q [DEPTH];
  logic [EW-1:0] new_entry;

  assign new_entry = {cy, cx, key};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [EW-1:0] prev_q;
    logic [EW-1:0] next_q;

    if (g == 0) begin : g_first
      assign prev_q = '0;
    end else begin : g_mid
      assign prev_q = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_q = cell_q[0];
    end else begin : g_body
      assign next_q = cell_q[g+1];
    end

    sle_cell #(
      .IW    (IW),
      .EW    (EW),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .slot      (slot),
      .new_entry (new_entry),
      .from_prev (prev_q),
      .from_next (next_q),
      .entry     (cell_q[g])
    );
  end

  // head cell compare during the scan
  logic [EW-1:0]          head;
  logic [NAME_W-1:0]      head_name;
  logic [COORD_WIDTH-1:0] head_x;
  logic [COORD_WIDTH-1:0] head_y;
  logic                   in_range;
  logic                   hit;
  logic                   last_step;

  assign head      = cell_q[0];
  assign head_name = head[NAME_W-1:0];
  assign head_x    = head[NAME_W +: COORD_WIDTH];
  assign head_y    = head[NAME_W + COORD_WIDTH +: COORD_WIDTH];
  assign in_range  = CW'(step) < count;
  assign last_step = (step == IW'(DEPTH - 1));

  always_comb begin
    case (cmd)
      CMD_FIND_NAME:  hit = (head_name == key);
      CMD_FIND_PLACE: hit = (head_x == cx) && (head_y == cy);
      CMD_DELETE:     hit = (step == slot);
      default:        hit = 1'b0;
    endcase
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // next state and cell operation
  always_comb begin
    state_next = state;
    cell_op    = CELL_HOLD;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (in_cmd)
            CMD_APPEND: begin
              state_next = is_full ? ST_DONE : ST_SHIFT;
            end
            CMD_INSERT: begin
              state_next = (ins_ok && !is_full) ? ST_SHIFT : ST_DONE;
            end
            CMD_DELETE: begin
              state_next = del_ok ? ST_SCAN : ST_DONE;
            end
            CMD_FIND_NAME, CMD_FIND_PLACE: begin
              state_next = ST_SCAN;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cell_op = CELL_ROTATE;
        if (last_step) begin
          state_next = (cmd == CMD_DELETE) ? ST_SHIFT : ST_DONE;
        end
      end
      ST_SHIFT: begin
        cell_op    = (cmd == CMD_DELETE) ? CELL_SHIFT_DOWN : CELL_SHIFT_UP;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SHIFT) begin
        if (cmd == CMD_DELETE) begin
          count <= count - CW'(1);
        end else begin
          count <= count + CW'(1);
        end
      end
    end
  end

  // command capture, scan progress and result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= in_cmd;
      key        <= in_key;
      cx         <= in_x;
      cy         <= in_y;
      step       <= '0;
      found      <= 1'b0;
      res_pos    <= '0;
      res_entry  <= '0;
      res_status <= STAT_OK;
      case (in_cmd)
        CMD_APPEND: begin
          slot <= IW'(count);
          if (is_full) begin
            res_status <= STAT_FULL;
          end
        end
        CMD_INSERT: begin
          slot <= IW'(pos_e - PW'(1));
          if (!ins_ok) begin
            res_status <= STAT_BAD_POS;
          end else if (is_full) begin
            res_status <= STAT_FULL;
          end
        end
        CMD_DELETE: begin
          slot <= IW'(pos_e - PW'(1));
          if (!del_ok) begin
            res_status <= STAT_BAD_POS;
          end
        end
        CMD_FIND_NAME, CMD_FIND_PLACE: begin
          slot       <= '0;
          res_status <= STAT_NOT_FOUND;
        end
        default: begin
          slot <= '0;
        end
      endcase
    end else if (state == ST_SCAN) begin
      step <= step + IW'(1);
      if (!found && in_range && hit) begin
        found      <= 1'b1;
        res_status <= STAT_OK;
        res_pos    <= POS_W'(PW'(step) + PW'(1));
        res_entry  <= head;
      end
    end else if (state == ST_SHIFT && cmd != CMD_DELETE) begin
      res_pos   <= POS_W'(PW'(slot) + PW'(1));
      res_entry <= new_entry;
    end
  end

  // output register, loaded once the previous result has been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{(TDATA_W - OUT_BITS){1'b0}},
                  coord_out(res_entry[NAME_W + COORD_WIDTH +: COORD_WIDTH]),
                  coord_out(res_entry[NAME_W +: COORD_WIDTH]),
                  res_entry[NAME_W-1:0],
                  res_pos,
                  res_status};
    end
  end

endmodule : sequential_list_engine

`default_nettype wire
